[src/sem_pkg.sv]
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies; used by sem_front, sem_queue, sem_back and the top level.
package sem_pkg;

    localparam int unsigned CfgWidthBits = 11;
    localparam int unsigned PixBits      = 24;
    localparam logic [20:0] SatLimit     = 21'd65281;
    localparam logic [7:0]  SatValue     = 8'd255;

    // Register indexes of the configuration port.
    localparam logic CfgFrameWidth  = 1'b0;
    localparam logic CfgFrameHeight = 1'b1;

    // What a queued item produces.
    typedef enum logic [1:0] {
        K_NONE = 2'd0,  // updates the stores and window only
        K_LAST = 2'd1,  // result for the last column of an earlier row
        K_MID  = 2'd2   // result for the pixel left of the current column
    } t_kind;

    typedef struct packed {
        logic [PixBits-1:0] pix;
        t_kind              kind;
        logic [2:0]         row_mask;
        logic [2:0]         col_mask;
        logic               done;
    } t_task;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_WIN  = 3'd1,
        S_SQR  = 3'd2,
        S_ROOT = 3'd3,
        S_RND  = 3'd4
    } t_bstate;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

[src/sem_queue.sv]
// Two-entry queue between the front and back parts.
// Depends on sem_pkg for the status struct.
module sem_queue import sem_pkg::*; #(
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output t_qstat        o_stat
);

    logic [DW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule

[src/sem_front.sv]
// Front part: accepts items, tracks the frame position and classifies each item.
// Depends on sem_pkg for the task struct and kind codes.
module sem_front import sem_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int CI = $clog2(MAX_WIDTH),
    localparam int CW = $clog2(MAX_WIDTH + 1),
    localparam int RW = $clog2(MAX_HEIGHT + 2),
    localparam int XW = RW + 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_req_type,
    input  logic [7:0]              i_red_in,
    input  logic [7:0]              i_green_in,
    input  logic [7:0]              i_blue_in,
    input  logic [CfgWidthBits-1:0] i_cfg_width,
    input  logic [CfgWidthBits-1:0] i_cfg_height,
    input  t_qstat                  i_qstat,
    output logic                    o_push,
    output t_task                   o_task,
    output logic [CI-1:0]           o_col
);

    logic          r_active;
    logic [CW-1:0] r_lw;
    logic [RW-1:0] r_lh;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    logic          take, start, ignore, pix_row, col_zero, done;
    logic [CW-1:0] w_clamp, lw_e, col_e;
    logic [RW-1:0] h_clamp, lh_e, row_e;
    logic [XW-1:0] xr, xh;
    logic [CW:0]   col_inc;
    t_kind         kind;
    logic [2:0]    rmask, cmask;

    assign o_ready = !i_qstat.full;
    assign take    = i_valid && o_ready;

    always_comb begin
        if (i_cfg_width == '0)                      w_clamp = CW'(1);
        else if (32'(i_cfg_width) > MAX_WIDTH)      w_clamp = CW'(MAX_WIDTH);
        else                                        w_clamp = CW'(i_cfg_width);
        if (i_cfg_height == '0)                     h_clamp = RW'(1);
        else if (32'(i_cfg_height) > MAX_HEIGHT)    h_clamp = RW'(MAX_HEIGHT);
        else                                        h_clamp = RW'(i_cfg_height);
    end

    always_comb begin
        start    = !r_active && !i_req_type;
        lw_e     = start ? w_clamp : r_lw;
        lh_e     = start ? h_clamp : r_lh;
        row_e    = start ? '0 : r_row;
        col_e    = start ? '0 : r_col;
        pix_row  = (row_e < lh_e);
        ignore   = i_req_type && (!r_active || pix_row);
        xr       = XW'(row_e);
        xh       = XW'(lh_e);
        col_zero = (col_e == '0);
        col_inc  = {1'b0, col_e} + 1'b1;

        if (col_zero && xr >= XW'(2))       kind = K_LAST;
        else if (!col_zero && xr >= XW'(1)) kind = K_MID;
        else                                kind = K_NONE;

        rmask = '0;
        cmask = '0;
        done  = 1'b0;
        case (kind)
            K_LAST: begin
                rmask[0] = (xr >= XW'(3)) && (xr < xh + XW'(3));
                rmask[1] = (xr < xh + XW'(2));
                rmask[2] = (xr < xh + XW'(1));
                cmask    = {1'b0, 1'b1, (lw_e >= CW'(2))};
                done     = (xr == xh + XW'(1));
            end
            K_MID: begin
                rmask[0] = (xr >= XW'(2)) && (xr < xh + XW'(2));
                rmask[1] = (xr < xh + XW'(1));
                rmask[2] = (xr < xh);
                cmask    = {1'b1, 1'b1, (col_e >= CW'(2))};
            end
            default: ;
        endcase
    end

    assign o_push          = take && !ignore;
    assign o_task.pix      = pix_row ? {i_red_in, i_green_in, i_blue_in} : '0;
    assign o_task.kind     = kind;
    assign o_task.row_mask = rmask;
    assign o_task.col_mask = cmask;
    assign o_task.done     = done;
    assign o_col           = col_e[CI-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_lw     <= '0;
            r_lh     <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else if (o_push) begin
            r_lw <= lw_e;
            r_lh <= lh_e;
            if (done) begin
                r_active <= 1'b0;
                r_col    <= '0;
                r_row    <= '0;
            end else begin
                r_active <= 1'b1;
                if (col_inc >= {1'b0, lw_e}) begin
                    r_col <= '0;
                    r_row <= row_e + 1'b1;
                end else begin
                    r_col <= col_inc[CW-1:0];
                    r_row <= row_e;
                end
            end
        end
    end

endmodule

[src/sem_back.sv]
// Back part: line stores, 3x3 window, Sobel gradients, bit-serial square root, output register.
// Depends on sem_pkg for the task struct, kind codes and state enum.
module sem_back import sem_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    localparam int CI = $clog2(MAX_WIDTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_qstat        i_qstat,
    output logic          o_pop,
    input  t_task         i_task,
    input  logic [CI-1:0] i_col,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_red_edge,
    output logic [7:0]    o_green_edge,
    output logic [7:0]    o_blue_edge,
    output logic          o_frame_done
);

    logic [PixBits-1:0] upper_mem  [MAX_WIDTH];
    logic [PixBits-1:0] middle_mem [MAX_WIDTH];

    t_bstate r_state, n_state;
    t_task   r_task;
    logic [CI-1:0]      r_col;
    logic [PixBits-1:0] r_top, r_mid;
    logic [PixBits-1:0] r_win [3][3];
    logic signed [10:0] r_gx [3];
    logic signed [10:0] r_gy [3];
    logic [20:0]        r_n [3];
    logic [7:0]         r_root [3];
    logic [2:0]         r_bit;
    logic               r_ov;
    logic [7:0]         r_edge [3];
    logic               r_done;

    logic out_free, load_out, wr_en;
    logic [PixBits-1:0] nb [3][3];
    logic signed [10:0] gx [3];
    logic signed [10:0] gy [3];
    logic [20:0]        nsum [3];
    logic [7:0]         root_nx [3];
    logic [7:0]         mag [3];

    assign out_free = !r_ov || i_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_qstat.empty) n_state = S_WIN;
            S_WIN:  n_state = (r_task.kind == K_NONE) ? S_IDLE : S_SQR;
            S_SQR:  n_state = S_ROOT;
            S_ROOT: if (r_bit == 3'd0) n_state = S_RND;
            S_RND:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_pop    = 1'b0;
        wr_en    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: o_pop    = !i_qstat.empty;
            S_WIN:  wr_en    = 1'b1;
            S_RND:  load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Line stores: read on pop, written back in the next cycle from the window state.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_top  <= upper_mem[i_col];
            r_mid  <= middle_mem[i_col];
            r_task <= i_task;
            r_col  <= i_col;
        end
        if (wr_en) begin
            upper_mem[r_col]  <= r_mid;
            middle_mem[r_col] <= r_task.pix;
        end
    end

    // Neighborhood with out-of-frame pixels forced to black.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            nb[k][0] = r_task.col_mask[0] ? r_win[k][1] : '0;
            nb[k][1] = r_task.col_mask[1] ? r_win[k][2] : '0;
            nb[k][2] = '0;
        end
        if (r_task.kind == K_MID && r_task.col_mask[2]) begin
            nb[0][2] = r_top;
            nb[1][2] = r_mid;
            nb[2][2] = r_task.pix;
        end
        for (int k = 0; k < 3; k++) begin
            if (!r_task.row_mask[k]) begin
                for (int j = 0; j < 3; j++) nb[k][j] = '0;
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            gx[ch] = (11'(nb[0][2][16-8*ch +: 8]) + (11'(nb[1][2][16-8*ch +: 8]) <<< 1)
                    + 11'(nb[2][2][16-8*ch +: 8]))
                   - (11'(nb[0][0][16-8*ch +: 8]) + (11'(nb[1][0][16-8*ch +: 8]) <<< 1)
                    + 11'(nb[2][0][16-8*ch +: 8]));
            gy[ch] = (11'(nb[2][0][16-8*ch +: 8]) + (11'(nb[2][1][16-8*ch +: 8]) <<< 1)
                    + 11'(nb[2][2][16-8*ch +: 8]))
                   - (11'(nb[0][0][16-8*ch +: 8]) + (11'(nb[0][1][16-8*ch +: 8]) <<< 1)
                    + 11'(nb[0][2][16-8*ch +: 8]));
        end
    end

    always_comb begin
        logic [9:0]  ax, ay;
        logic [7:0]  t;
        logic [15:0] sq;
        logic [16:0] rr;
        for (int ch = 0; ch < 3; ch++) begin
            ax = r_gx[ch][10] ? 10'(-r_gx[ch]) : r_gx[ch][9:0];
            ay = r_gy[ch][10] ? 10'(-r_gy[ch]) : r_gy[ch][9:0];
            nsum[ch] = 21'({10'd0, ax} * {10'd0, ax}) + 21'({10'd0, ay} * {10'd0, ay});
            t  = r_root[ch] | (8'd1 << r_bit);
            sq = {8'd0, t} * {8'd0, t};
            root_nx[ch] = ({5'd0, sq} <= r_n[ch]) ? t : r_root[ch];
            rr = 17'({8'd0, r_root[ch]} * {8'd0, r_root[ch]}) + 17'(r_root[ch]);
            if (r_n[ch] >= SatLimit)       mag[ch] = SatValue;
            else if (r_n[ch] > 21'(rr))    mag[ch] = r_root[ch] + 8'd1;
            else                           mag[ch] = r_root[ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) r_win[k][j] <= '0;
            end
        end else if (r_state == S_WIN) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= r_top;
            r_win[1][2] <= r_mid;
            r_win[2][2] <= r_task.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_WIN: begin
                r_gx <= gx;
                r_gy <= gy;
            end
            S_SQR: begin
                r_n <= nsum;
                for (int ch = 0; ch < 3; ch++) r_root[ch] <= '0;
                r_bit <= 3'd7;
            end
            S_ROOT: begin
                r_root <= root_nx;
                r_bit  <= r_bit - 3'd1;
            end
            default: ;
        endcase
        if (load_out) begin
            r_edge <= mag;
            r_done <= r_task.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_ov <= 1'b0;
        else if (load_out) r_ov <= 1'b1;
        else if (i_ready)  r_ov <= 1'b0;
    end

    assign o_valid      = r_ov;
    assign o_red_edge   = r_edge[0];
    assign o_green_edge = r_edge[1];
    assign o_blue_edge  = r_edge[2];
    assign o_frame_done = r_done;

endmodule

[src/sobel_edge_magnitude_rgb.sv]
// Top level of the Sobel edge magnitude block for RGB pixel streams.
// Depends on sem_pkg, sem_front, sem_queue and sem_back.
//
// Usage: pixels enter in raster order on the input channel (i_valid/o_ready)
// with i_req_type low; after the last pixel of a frame the sender issues
// frame_width+1 drain items (i_req_type high) to flush the pending results.
// Each result leaves on the output channel (o_valid/i_ready) with one edge
// magnitude per color and o_frame_done set on the frame's last pixel.
// Results trail the input by one row plus one pixel in item count.
// The front accepts and classifies an item combinationally and queues it in a
// two-entry queue. The back reads the line stores and updates the window and
// gradients for every item; for one that yields a result it also forms the
// squares, then the one-bit-a-cycle square root and rounding into the output
// register. It takes no new item until it is through with the last one.
// The square root loop in the back therefore sets the sustained rate while
// results are being produced.
// Reset empties the queue, clears the window and the output valid flag and
// loads both size registers with 1024; the line stores are not cleared.
// A stalled receiver holds the back in its rounding step; the queue still
// takes items until it is full, then o_ready drops.
module sobel_edge_magnitude_rgb import sem_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_req_type,
    input  logic [7:0]              i_red_in,
    input  logic [7:0]              i_green_in,
    input  logic [7:0]              i_blue_in,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [7:0]              o_red_edge,
    output logic [7:0]              o_green_edge,
    output logic [7:0]              o_blue_edge,
    output logic                    o_frame_done,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_idx,
    input  logic [CfgWidthBits-1:0] i_cfg_data
);

    localparam int CI = $clog2(MAX_WIDTH);
    localparam int QW = CI + $bits(t_task);

    logic [CfgWidthBits-1:0] r_frame_width;
    logic [CfgWidthBits-1:0] r_frame_height;

    // Size registers; the front samples them when a frame starts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CfgWidthBits'(1024);
            r_frame_height <= CfgWidthBits'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgFrameWidth:  r_frame_width  <= i_cfg_data;
                CfgFrameHeight: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_qstat        qstat;
    logic          q_push, q_pop;
    t_task         f_task, b_task;
    logic [CI-1:0] f_col, b_col;

    sem_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_cfg_width  (r_frame_width),
        .i_cfg_height (r_frame_height),
        .i_qstat      (qstat),
        .o_push       (q_push),
        .o_task       (f_task),
        .o_col        (f_col)
    );

    sem_queue #(
        .DW (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_col, f_task}),
        .i_pop   (q_pop),
        .o_data  ({b_col, b_task}),
        .o_stat  (qstat)
    );

    sem_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_qstat      (qstat),
        .o_pop        (q_pop),
        .i_task       (b_task),
        .i_col        (b_col),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red_edge   (o_red_edge),
        .o_green_edge (o_green_edge),
        .o_blue_edge  (o_blue_edge),
        .o_frame_done (o_frame_done)
    );

    // The front never writes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !qstat.full)
        else $error("queue written while full");

    // The back never takes from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !qstat.empty)
        else $error("queue read while empty");

    // No result is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

endmodule
